>>> rtl/sql_token_scanner_unit_assert.svh
// Assertion macros shared by the checker of the token scanner.
`ifndef SQL_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define SQL_TOKEN_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define STS_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("sql_token_scanner_unit: assertion failed");

// Next-cycle implication, off while reset is high.
`define STS_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("sql_token_scanner_unit: assertion failed");

// Checks what reset leaves behind in the following cycle.
`define STS_ASSERT_RESET(name, post) \
   name: assert property (@(posedge clock) reset |=> (post)) \
      else $error("sql_token_scanner_unit: assertion failed");

`endif

>>> rtl/sts_pkg.sv
// Types, codes and the keyword table of the SQL token scanner.
package sts_pkg;

   localparam int KW_COUNT     = 319;
   localparam int KW_MAX_CHARS = 18;
   localparam int KW_BITS      = 8 * KW_MAX_CHARS;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [19:0] LINE_TOP  = 20'hFFFFF;
   localparam logic [15:0] COL_TOP   = 16'hFFFF;
   localparam logic [11:0] LEN_TOP   = 12'hFFF;
   localparam logic [30:0] INT_LIMIT = 31'h7FFFFFFF;
   localparam logic [4:0]  TAB_RESET = 5'd8;

   localparam logic [4:0] KIND_EOF      = 5'd0;
   localparam logic [4:0] KIND_IDENT    = 5'd1;
   localparam logic [4:0] KIND_KEYWORD  = 5'd2;
   localparam logic [4:0] KIND_INT      = 5'd3;
   localparam logic [4:0] KIND_REAL     = 5'd4;
   localparam logic [4:0] KIND_STRING   = 5'd5;
   localparam logic [4:0] KIND_UNKNOWN  = 5'd6;
   localparam logic [4:0] KIND_SEMI     = 5'd7;
   localparam logic [4:0] KIND_SLASH    = 5'd8;
   localparam logic [4:0] KIND_LBRACE   = 5'd9;
   localparam logic [4:0] KIND_RBRACE   = 5'd10;
   localparam logic [4:0] KIND_COMMA    = 5'd11;
   localparam logic [4:0] KIND_LPAREN   = 5'd12;
   localparam logic [4:0] KIND_RPAREN   = 5'd13;
   localparam logic [4:0] KIND_LBRACKET = 5'd14;
   localparam logic [4:0] KIND_RBRACKET = 5'd15;
   localparam logic [4:0] KIND_STAR     = 5'd16;
   localparam logic [4:0] KIND_PERCENT  = 5'd17;
   localparam logic [4:0] KIND_HASH     = 5'd18;
   localparam logic [4:0] KIND_PLUS     = 5'd19;
   localparam logic [4:0] KIND_MINUS    = 5'd20;
   localparam logic [4:0] KIND_EQUAL    = 5'd21;
   localparam logic [4:0] KIND_MERGE    = 5'd22;
   localparam logic [4:0] KIND_NE       = 5'd23;
   localparam logic [4:0] KIND_ASSIGN   = 5'd24;
   localparam logic [4:0] KIND_COLON    = 5'd25;
   localparam logic [4:0] KIND_LE       = 5'd26;
   localparam logic [4:0] KIND_LT       = 5'd27;
   localparam logic [4:0] KIND_GE       = 5'd28;
   localparam logic [4:0] KIND_GT       = 5'd29;
   localparam logic [4:0] KIND_DOT      = 5'd30;
   localparam logic [4:0] KIND_ERROR    = 5'd31;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_STRING   = 2'd1;
   localparam logic [1:0] ERR_NAME     = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_DROP,
      MODE_WORD,
      MODE_NUMBER,
      MODE_DOT,
      MODE_STRING,
      MODE_OP
   } mode_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SEARCH,
      BACK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [4:0]         kind;
      logic [8:0]         kw_index;
      logic [11:0]        length;
      logic [19:0]        line;
      logic [15:0]        column;
      logic [30:0]        value;
      logic [1:0]         err;
      logic               last;
      logic               lookup;
      logic [KW_BITS-1:0] word;
   } token_rec_type;

   typedef struct packed {
      logic [1:0]    cnt;
      token_rec_type rec0;
      token_rec_type rec1;
   } push_type;

   // Keyword names, right-aligned and zero-padded like the word register.
   localparam logic [KW_BITS-1:0] KW_TABLE [KW_COUNT] = '{
      "MONEY","DATETIME","INTEGER64",
      "ABSOLUTE","ACTION","ADD","ADMIN","AFTER","AGGREGATE",
      "ALIAS","ALL","ALLOCATE","ALTER","AND","ANY","ARE","ARRAY","AS","ASC",
      "ASSERTION","AT","AUTHORIZATION",
      "BEFORE","BEGIN","BINARY","BIT","BLOB","BOOLEAN","BOTH","BREADTH","BY",
      "CALL","CASCADE","CASCADED","CASE","CAST","CATALOG","CHAR","CHARACTER",
      "CHECK","CLASS","CLOB","CLOSE","COLLATE","COLLATION","COLUMN","COMMIT",
      "COMPLETION","CONNECT","CONNECTION","CONSTRAINT","CONSTRAINTS",
      "CONSTRUCTOR","CONTINUE","CORRESPONDING","CREATE","CROSS","CUBE","CURRENT",
      {"CURRENT","_DATE"},{"CURRENT","_PATH"},{"CURRENT","_ROLE"},{"CURRENT","_TIME"},
      {"CURRENT","_TIMESTAMP"},
      {"CURRENT","_USER"},"CURSOR","CYCLE",
      "DATA","DATE","DAY","DEALLOCATE","DEC","DECIMAL","DECLARE","DEFAULT",
      "DEFERRABLE","DEFERRED","DELETE","DEPTH","DEREF","DESC","DESCRIBE",
      "DESCRIPTOR",
      "DESTROY","DESTRUCTOR","DETERMINISTIC","DICTIONARY","DIAGNOSTICS",
      "DISCONNECT",
      "DISTINCT","DOMAIN","DOUBLE","DROP","DYNAMIC",
      "EACH","ELSE","END","EQUALS","ESCAPE","EVERY","EXCEPT",
      "EXCEPTION","EXEC","EXECUTE","EXTERNAL",
      "FALSE","FETCH","FIRST","FLOAT","FOR","FOREIGN","FOUND","FROM","FREE","FULL",
      "FUNCTION",
      "GENERAL","GET","GLOBAL","GO","GOTO","GRANT","GROUP","GROUPING",
      "HAVING","HOST","HOUR",
      "IDENTITY","IGNORE","IMMEDIATE","IN","INDICATOR","INITIALIZE","INITIALLY",
      "INNER","INOUT","INPUT","INSERT","INT","INTEGER","INTERSECT","INTERVAL",
      "INTO","IS","ISOLATION","ITERATE",
      "JOIN","KEY",
      "LANGUAGE","LARGE","LAST","LATERAL","LEADING","LEFT","LESS","LEVEL","LIKE",
      "LIMIT",
      "LOCAL","LOCALTIME","LOCALTIMESTAMP","LOCATOR","MAP","MATCH","MINUTE",
      "MODIFIES",
      "MODIFY","MODULE","MONTH",
      "NAMES","NATIONAL","NATURAL","NCHAR","NCLOB","NEW","NEXT","NO","NONE",
      "NOT","NULL","NUMERIC",
      "OBJECT","OF","OFF","OLD","ON","ONLY","OPEN","OPERATION","OPTION",
      "OR","ORDER","ORDINALITY","OUT","OUTER","OUTPUT","OWNER",
      "PAD","PARAMETER","PARAMETERS","PARTIAL","PATH","POSTFIX","PRECISION",
      "PREFIX",
      "PREORDER","PREPARE","PRESERVE","PRIMARY",
      "PRIOR","PRIVILEGES","PROCEDURE","PUBLIC",
      "READ","READS","REAL","RECURSIVE","REF","REFERENCES","REFERENCING",
      "RELATIVE",
      "RESTRICT","RESULT","RETURN","RETURNS","REVOKE","RIGHT",
      "ROLE","ROLLBACK","ROLLUP","ROUTINE","ROW","ROWS",
      "SAVEPOINT","SCHEMA","SCROLL","SCOPE","SEARCH","SECOND","SECTION","SELECT",
      "SEQUENCE","SESSION",{"SESSION","_USER"},"SET","SETS","SIZE","SMALLINT","SOME",
      "SPACE",
      "SPECIFIC","SPECIFICTYPE","SQL","SQLEXCEPTION","SQLSTATE","SQLWARNING",
      "START",
      "STATE","STATEMENT","STATIC","STRUCTURE",{"SYSTEM","_USER"},
      "TABLE","TEMPORARY","TERMINATE","THAN","THEN","TIME","TIMESTAMP",
      {"TIMEZONE","_HOUR"},"TIMEZONE_MINUTE","TO","TRAILING","TRANSACTION",
      "TRANSLATION",
      "TREAT","TRIGGER","TRUE",
      "UNDER","UNION","UNIQUE","UNKNOWN",
      "UNNEST","UPDATE","USAGE","USER","USING",
      "VALUE","VALUES","VARCHAR","VARIABLE","VARYING","VIEW",
      "WHEN","WHENEVER","WHERE","WITH","WITHOUT","WORK","WRITE",
      "YEAR","ZONE",
      "_SYSTEM","AUTONUMBER","READACCESSMANAGER","WRITEACCESSMANAGER","NOUPDATE",
      "NOCIRCULAIRS","MAXLENGTH","INDEX","INTERNAL","UPPERCASE","GRANTED","RENAME",
      "WAIT","SHOW","MOVE",{"REFRESH","_METADATA"},"NONULLSTORES"
   };

endpackage

>>> rtl/sts_front.sv
// Byte scanner: classifies each input byte and pushes finished token words.
module sts_front #(
   parameter int MAX_NAME_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic [4:0]        tab_width,
   output sts_pkg::push_type push
);
   import sts_pkg::*;

   mode_type           mode_ff, mode_in;
   logic [7:0]         quote_ff, quote_in;
   logic               esc_ff, esc_in;
   logic [7:0]         op_ff, op_in;
   logic               real_ff, real_in;
   logic [11:0]        len_ff, len_in;
   logic [19:0]        line_ff, line_in;
   logic [15:0]        col_ff, col_in;
   logic [19:0]        tline_ff, tline_in;
   logic [15:0]        tcol_ff, tcol_in;
   logic [30:0]        num_ff, num_in;
   logic               ovf_ff, ovf_in;
   logic [KW_BITS-1:0] word_ff, word_in;
   token_rec_type      recs [2];
   logic [1:0]         cnt;

   function automatic logic is_space(logic [7:0] b);
      return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_word_start(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b == "_");
   endfunction

   function automatic logic [7:0] to_upper(logic [7:0] b);
      return (b >= "a" && b <= "z") ? (b - 8'd32) : b;
   endfunction

   function automatic logic [4:0] punct_kind(logic [7:0] b);
      logic [4:0] k;
      unique case (b)
         ";":     k = KIND_SEMI;
         "/":     k = KIND_SLASH;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ",":     k = KIND_COMMA;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "[":     k = KIND_LBRACKET;
         "]":     k = KIND_RBRACKET;
         "*":     k = KIND_STAR;
         "%":     k = KIND_PERCENT;
         "#":     k = KIND_HASH;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "=":     k = KIND_EQUAL;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

   function automatic logic [15:0] next_col(logic [15:0] c, logic [7:0] b, logic [4:0] tab);
      logic [16:0] s;
      s = {1'b0, c} + ((b == 8'd9) ? {12'd0, tab} : 17'd1);
      if (b == 8'd10) begin
         return 16'd1;
      end
      return (s > {1'b0, COL_TOP}) ? COL_TOP : s[15:0];
   endfunction

   function automatic logic [19:0] next_line(logic [19:0] l, logic [7:0] b);
      return (b == 8'd10 && l < LINE_TOP) ? (l + 20'd1) : l;
   endfunction

   function automatic token_rec_type make_rec(logic [4:0] k, logic [11:0] l,
                                              logic [19:0] ln, logic [15:0] cl,
                                              logic [30:0] v, logic [1:0] e,
                                              logic lk, logic [KW_BITS-1:0] w);
      token_rec_type r;
      r = '0;
      r.kind   = k;
      r.length = l;
      r.line   = ln;
      r.column = cl;
      r.value  = v;
      r.err    = e;
      r.lookup = lk;
      r.word   = w;
      return r;
   endfunction

   always_comb begin
      logic [7:0]  b;
      logic        restart;
      logic [4:0]  pair_kind;
      logic [4:0]  single_kind;
      logic [4:0]  pk;
      logic [34:0] prod;
      b           = in_byte;
      restart     = 1'b0;
      pair_kind   = KIND_EOF;
      single_kind = KIND_EOF;
      pk          = KIND_EOF;
      prod        = '0;
      cnt         = 2'd0;
      recs[0]     = '0;
      recs[1]     = '0;
      mode_in     = mode_ff;
      quote_in    = quote_ff;
      esc_in      = esc_ff;
      op_in       = op_ff;
      real_in     = real_ff;
      len_in      = len_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      tline_in    = tline_ff;
      tcol_in     = tcol_ff;
      num_in      = num_ff;
      ovf_in      = ovf_ff;
      word_in     = word_ff;

      unique case (mode_ff)
         MODE_DROP: begin
            if (b == 8'd0) begin
               mode_in = MODE_IDLE;
               line_in = 20'd1;
               col_in  = 16'd1;
            end
         end
         MODE_OP: begin
            case (op_ff)
               ":": begin
                  if (b == "=") pair_kind = KIND_ASSIGN;
                  else single_kind = KIND_COLON;
               end
               "<": begin
                  if (b == "=") pair_kind = KIND_LE;
                  else if (b == ">") pair_kind = KIND_NE;
                  else single_kind = KIND_LT;
               end
               ">": begin
                  if (b == "=") pair_kind = KIND_GE;
                  else single_kind = KIND_GT;
               end
               "|": begin
                  if (b == "|") pair_kind = KIND_MERGE;
               end
               "!": begin
                  if (b == "=") pair_kind = KIND_NE;
               end
               default: ;
            endcase
            mode_in = MODE_IDLE;
            if (pair_kind != KIND_EOF) begin
               line_in = next_line(line_ff, b);
               col_in  = next_col(col_ff, b, tab_width);
               recs[cnt[0]] = make_rec(pair_kind, 12'd2, tline_ff, tcol_ff, '0, ERR_NONE,
                                       1'b0, '0);
               cnt = cnt + 2'd1;
            end else if (single_kind != KIND_EOF) begin
               recs[cnt[0]] = make_rec(single_kind, 12'd1, tline_ff, tcol_ff, '0,
                                       ERR_NONE, 1'b0, '0);
               cnt = cnt + 2'd1;
               restart = 1'b1;
            end else if (b == 8'd0 || is_space(b)) begin
               recs[cnt[0]] = make_rec(KIND_UNKNOWN, 12'd1, tline_ff, tcol_ff, '0,
                                       ERR_NONE, 1'b0, '0);
               cnt = cnt + 2'd1;
               restart = 1'b1;
            end else begin
               line_in = next_line(line_ff, b);
               col_in  = next_col(col_ff, b, tab_width);
               recs[cnt[0]] = make_rec(KIND_UNKNOWN, 12'd2, tline_ff, tcol_ff, '0,
                                       ERR_NONE, 1'b0, '0);
               cnt = cnt + 2'd1;
            end
         end
         MODE_DOT: begin
            if (is_digit(b)) begin
               line_in = next_line(line_ff, b);
               col_in  = next_col(col_ff, b, tab_width);
               len_in  = (len_ff < LEN_TOP) ? (len_ff + 12'd1) : len_ff;
               real_in = 1'b1;
               ovf_in  = 1'b0;
               num_in  = '0;
               mode_in = MODE_NUMBER;
            end else begin
               recs[cnt[0]] = make_rec(KIND_DOT, 12'd1, tline_ff, tcol_ff, '0, ERR_NONE,
                                       1'b0, '0);
               cnt = cnt + 2'd1;
               restart = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(b) || b == ".") begin
               if (b == ".") begin
                  real_in = 1'b1;
               end else if (!ovf_ff) begin
                  prod = ({4'd0, num_ff} << 3) + ({4'd0, num_ff} << 1) + {31'd0, b[3:0]};
                  if (prod > {4'd0, INT_LIMIT}) begin
                     ovf_in = 1'b1;
                  end else begin
                     num_in = prod[30:0];
                  end
               end
               line_in = next_line(line_ff, b);
               col_in  = next_col(col_ff, b, tab_width);
               len_in  = (len_ff < LEN_TOP) ? (len_ff + 12'd1) : len_ff;
            end else if (!real_ff && ovf_ff) begin
               recs[cnt[0]] = make_rec(KIND_ERROR, len_ff, tline_ff, tcol_ff, '0,
                                       ERR_OVERFLOW, 1'b0, '0);
               cnt = cnt + 2'd1;
               if (b == 8'd0) begin
                  mode_in = MODE_IDLE;
                  line_in = 20'd1;
                  col_in  = 16'd1;
               end else begin
                  mode_in = MODE_DROP;
               end
            end else begin
               recs[cnt[0]] = make_rec(real_ff ? KIND_REAL : KIND_INT, len_ff, tline_ff,
                                       tcol_ff, real_ff ? '0 : num_ff, ERR_NONE, 1'b0,
                                       '0);
               cnt = cnt + 2'd1;
               restart = 1'b1;
            end
         end
         MODE_WORD: begin
            if (is_word_start(b) || is_digit(b)) begin
               word_in = {word_ff[KW_BITS-9:0], to_upper(b)};
               line_in = next_line(line_ff, b);
               col_in  = next_col(col_ff, b, tab_width);
               len_in  = (len_ff < LEN_TOP) ? (len_ff + 12'd1) : len_ff;
            end else if (len_ff > 12'(MAX_NAME_LEN)) begin
               recs[cnt[0]] = make_rec(KIND_ERROR, len_ff, tline_ff, tcol_ff, '0,
                                       ERR_NAME, 1'b0, '0);
               cnt = cnt + 2'd1;
               if (b == 8'd0) begin
                  mode_in = MODE_IDLE;
                  line_in = 20'd1;
                  col_in  = 16'd1;
               end else begin
                  mode_in = MODE_DROP;
               end
            end else begin
               recs[cnt[0]] = make_rec(KIND_IDENT, len_ff, tline_ff, tcol_ff, '0, ERR_NONE,
                                       len_ff <= 12'(KW_MAX_CHARS), word_ff);
               cnt = cnt + 2'd1;
               restart = 1'b1;
            end
         end
         MODE_STRING: begin
            if ((esc_ff && b == 8'd0) ||
                (!esc_ff && (b == 8'd0 || b == 8'd10 || b == 8'd13))) begin
               recs[cnt[0]] = make_rec(KIND_ERROR, len_ff, tline_ff, tcol_ff, '0,
                                       ERR_STRING, 1'b0, '0);
               cnt = cnt + 2'd1;
               if (b == 8'd0) begin
                  mode_in = MODE_IDLE;
                  line_in = 20'd1;
                  col_in  = 16'd1;
               end else begin
                  mode_in = MODE_DROP;
               end
            end else begin
               line_in = next_line(line_ff, b);
               col_in  = next_col(col_ff, b, tab_width);
               len_in  = (len_ff < LEN_TOP) ? (len_ff + 12'd1) : len_ff;
               if (esc_ff) begin
                  esc_in = 1'b0;
               end else if (b == quote_ff) begin
                  recs[cnt[0]] = make_rec(KIND_STRING, len_in, tline_ff, tcol_ff, '0,
                                          ERR_NONE, 1'b0, '0);
                  cnt = cnt + 2'd1;
                  mode_in = MODE_IDLE;
               end else if (b == "\\") begin
                  esc_in = 1'b1;
               end
            end
         end
         MODE_IDLE: restart = 1'b1;
         default:   restart = 1'b1;
      endcase

      if (restart) begin
         mode_in = MODE_IDLE;
         if (is_space(b)) begin
            line_in = next_line(line_in, b);
            col_in  = next_col(col_in, b, tab_width);
         end else begin
            tline_in = line_in;
            tcol_in  = col_in;
            len_in   = 12'd0;
            if (b == 8'd0) begin
               recs[cnt[0]] = make_rec(KIND_EOF, 12'd0, tline_in, tcol_in, '0, ERR_NONE,
                                       1'b0, '0);
               cnt = cnt + 2'd1;
               line_in = 20'd1;
               col_in  = 16'd1;
            end else begin
               pk      = punct_kind(b);
               line_in = next_line(line_in, b);
               col_in  = next_col(col_in, b, tab_width);
               len_in  = 12'd1;
               if (pk != KIND_EOF) begin
                  recs[cnt[0]] = make_rec(pk, 12'd1, tline_in, tcol_in, '0, ERR_NONE,
                                          1'b0, '0);
                  cnt = cnt + 2'd1;
               end else if (b == ":" || b == "<" || b == ">" || b == "|" || b == "!") begin
                  op_in   = b;
                  mode_in = MODE_OP;
               end else if (b == "\"" || b == "'") begin
                  quote_in = b;
                  esc_in   = 1'b0;
                  mode_in  = MODE_STRING;
               end else if (is_digit(b)) begin
                  num_in  = {27'd0, b[3:0]};
                  ovf_in  = 1'b0;
                  real_in = 1'b0;
                  mode_in = MODE_NUMBER;
               end else if (b == ".") begin
                  mode_in = MODE_DOT;
               end else if (is_word_start(b)) begin
                  word_in = KW_BITS'(to_upper(b));
                  mode_in = MODE_WORD;
               end else begin
                  recs[cnt[0]] = make_rec(KIND_UNKNOWN, 12'd1, tline_in, tcol_in, '0,
                                          ERR_NONE, 1'b0, '0);
                  cnt = cnt + 2'd1;
               end
            end
         end
      end

      if (cnt != 2'd0) begin
         recs[cnt[1]].last = 1'b1;
      end
   end

   assign push.cnt  = accept ? cnt : 2'd0;
   assign push.rec0 = recs[0];
   assign push.rec1 = recs[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         quote_ff <= '0;
         esc_ff   <= 1'b0;
         op_ff    <= '0;
         real_ff  <= 1'b0;
         len_ff   <= '0;
         line_ff  <= 20'd1;
         col_ff   <= 16'd1;
         tline_ff <= 20'd1;
         tcol_ff  <= 16'd1;
         num_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         esc_ff   <= esc_in;
         op_ff    <= op_in;
         real_ff  <= real_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         num_ff   <= num_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

endmodule

>>> rtl/sts_queue.sv
// Short token queue between the byte scanner and the keyword stage.
module sts_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  sts_pkg::push_type      push,
   input  logic                   pop,
   output sts_pkg::token_rec_type head,
   output logic                   not_empty,
   output logic                   has_room
);
   import sts_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   token_rec_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign has_room  = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.cnt);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.cnt) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.rec0;
      end
      if (push.cnt == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.rec1;
      end
   end

endmodule

>>> rtl/sts_back.sv
// Keyword stage: searches the keyword table for words and drives the result register.
module sts_back #(
   parameter int KEYWORD_SLOTS = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sts_pkg::token_rec_type head,
   input  logic                   not_empty,
   output logic                   pop,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output sts_pkg::token_rec_type rsp_rec
);
   import sts_pkg::*;

   localparam int SLOT_COUNT = (KEYWORD_SLOTS < KW_COUNT) ? KEYWORD_SLOTS : KW_COUNT;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

   back_state_type     state_ff, state_in;
   token_rec_type      cur_ff, cur_in;
   token_rec_type      out_ff, out_in;
   logic               ovld_ff, ovld_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               more_ff, more_in;
   logic               rvld_ff, rvld_in;
   logic [SLOT_W-1:0]  ridx_ff;
   logic [KW_BITS-1:0] rdata_ff;
   logic               out_free;

   assign out_free  = !ovld_ff || rsp_ready;
   assign rsp_valid = ovld_ff;
   assign rsp_rec   = out_ff;

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      out_in   = out_ff;
      ovld_in  = ovld_ff && !rsp_ready;
      slot_in  = slot_ff;
      more_in  = more_ff;
      rvld_in  = 1'b0;
      pop      = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (not_empty) begin
               if (head.lookup) begin
                  cur_in   = head;
                  pop      = 1'b1;
                  slot_in  = '0;
                  more_in  = 1'b1;
                  state_in = BACK_SEARCH;
               end else if (out_free) begin
                  out_in  = head;
                  ovld_in = 1'b1;
                  pop     = 1'b1;
               end
            end
         end
         BACK_SEARCH: begin
            rvld_in = more_ff;
            if (more_ff) begin
               slot_in = slot_ff + SLOT_W'(1);
               more_in = (slot_ff != SLOT_LAST);
            end
            if (rvld_ff && rdata_ff == cur_ff.word) begin
               cur_in.kind     = KIND_KEYWORD;
               cur_in.kw_index = 9'(ridx_ff) + 9'd1;
               rvld_in         = 1'b0;
               state_in        = BACK_EMIT;
            end else if (rvld_ff && ridx_ff == SLOT_LAST) begin
               rvld_in  = 1'b0;
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               out_in   = cur_ff;
               ovld_in  = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         ovld_ff  <= 1'b0;
         more_ff  <= 1'b0;
         rvld_ff  <= 1'b0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ovld_ff  <= ovld_in;
         more_ff  <= more_in;
         rvld_ff  <= rvld_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      out_ff   <= out_in;
      rdata_ff <= KW_TABLE[slot_ff];
      ridx_ff  <= slot_ff;
   end

endmodule

>>> rtl/sql_token_scanner_unit.sv
// Top level of the SQL token scanner: register port, scanner, queue and keyword stage.
//
// The req channel takes one text byte per word; a zero byte ends the buffer.
// The rsp channel returns tokens: kind, keyword index, length, start line and
// column, integer value, error code and a last flag on the final token that
// a byte causes. A byte causes zero, one or two tokens.
// Bytes enter one per cycle while the queue has room for two tokens.
// A token that needs no keyword search passes a queue entry and then the
// result register on its way to rsp. A word of at most 18 characters is
// compared against the keyword table one slot a cycle, up to the first
// match or the last searched slot; bytes keep entering meanwhile until the
// queue fills. The result register holds a token until rsp_ready; the
// scanner stalls only through the queue. Reset clears the scanner, queue
// and result register and sets tab_width to 8. tab_width sits at byte
// address 0 of the csr port and is to be written by the user only while the
// block is idle; the block itself does not enforce it.
module sql_token_scanner_unit #(
   parameter int MAX_NAME_LEN  = 64,
   parameter int KEYWORD_SLOTS = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [8:0]  rsp_keyword_index,
   output logic [11:0] rsp_token_length,
   output logic [19:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic [30:0] rsp_int_value,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sts_pkg::*;

   localparam logic REG_TAB_WIDTH = 1'b0;

   logic [4:0]    tab_ff;
   logic          accept;
   logic          pop;
   logic          not_empty;
   logic          has_room;
   push_type      push;
   token_rec_type head;
   token_rec_type rsp_rec;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TAB_WIDTH) ? {27'd0, tab_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff <= TAB_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_TAB_WIDTH) begin
         tab_ff <= csr_pwdata[4:0];
      end
   end

   assign req_ready = has_room;
   assign accept    = req_valid && req_ready;

   sts_front #(
      .MAX_NAME_LEN(MAX_NAME_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .tab_width (tab_ff),
      .push      (push)
   );

   sts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   sts_back #(
      .KEYWORD_SLOTS(KEYWORD_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_rec   (rsp_rec)
   );

   assign rsp_token_kind    = rsp_rec.kind;
   assign rsp_keyword_index = rsp_rec.kw_index;
   assign rsp_token_length  = rsp_rec.length;
   assign rsp_start_line    = rsp_rec.line;
   assign rsp_start_column  = rsp_rec.column;
   assign rsp_int_value     = rsp_rec.value;
   assign rsp_error_code    = rsp_rec.err;
   assign rsp_last          = rsp_rec.last;

endmodule

>>> rtl/sts_checker.sv
// Port-level checker for the SQL token scanner and its bind to the top level.
`include "sql_token_scanner_unit_assert.svh"

module sts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_token_kind,
   input logic [8:0]  rsp_keyword_index,
   input logic [11:0] rsp_token_length,
   input logic [1:0]  rsp_error_code
);
   import sts_pkg::*;

   `STS_ASSERT_RESET(a_reset_empty, !rsp_valid)
   `STS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_token_kind))
   `STS_ASSERT_NOW(a_eof_length, rsp_valid && rsp_token_kind == KIND_EOF, rsp_token_length == 12'd0)
   `STS_ASSERT_NOW(a_error_kind, rsp_valid && rsp_error_code != ERR_NONE, rsp_token_kind == KIND_ERROR)
   `STS_ASSERT_NOW(a_keyword_index, rsp_valid, (rsp_keyword_index != 9'd0) == (rsp_token_kind == KIND_KEYWORD))

endmodule

bind sql_token_scanner_unit sts_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_token_kind    (rsp_token_kind),
   .rsp_keyword_index (rsp_keyword_index),
   .rsp_token_length  (rsp_token_length),
   .rsp_error_code    (rsp_error_code)
);

>>> verif/tb_sql_token_scanner_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SQL token scanner: random SQL text against a token predictor.
module tb_sql_token_scanner_unit;
   import sts_pkg::*;

   typedef struct {
      logic [4:0]  kind;
      logic [8:0]  kw;
      logic [11:0] len;
      logic [19:0] line;
      logic [15:0] col;
      logic [30:0] val;
      logic [1:0]  err;
      logic        last;
   } token_type;

   class token_scoreboard;
      mode_type     mode;
      logic [7:0]   quote, op_byte;
      bit           esc, is_real, ovf;
      int unsigned  cur_len, line_n, col_n, tok_line, tok_col, num_val;
      logic [7:0]   wbuf [64];
      logic [4:0]   tab;
      token_type    step_tokens[$];
      token_type    expected[$];
      int           mismatches, checked;

      function new();
         mode = MODE_IDLE;
         tab = TAB_RESET;
         line_n = 1; col_n = 1; tok_line = 1; tok_col = 1;
         cur_len = 0; num_val = 0;
      endfunction

      function bit is_space(logic [7:0] b);
         return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= "0" && b <= "9";
      endfunction

      function bit is_word_start(logic [7:0] b);
         return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
      endfunction

      function logic [7:0] upper(logic [7:0] b);
         return (b >= "a" && b <= "z") ? b - 8'd32 : b;
      endfunction

      function void emit(logic [4:0] kind, logic [8:0] kw, int unsigned len,
                         int unsigned val, logic [1:0] err);
         token_type t;
         if (step_tokens.size() >= 2) return;
         t.kind = kind; t.kw = kw; t.len = len[11:0];
         t.line = tok_line[19:0]; t.col = tok_col[15:0];
         t.val = val[30:0]; t.err = err; t.last = 1'b0;
         step_tokens.push_back(t);
      endfunction

      function void advance(logic [7:0] b);
         int unsigned inc;
         if (b == 8'd10) begin
            if (line_n < LINE_TOP) line_n++;
            col_n = 1;
            return;
         end
         inc = (b == 8'd9) ? tab : 1;
         col_n = (col_n + inc > COL_TOP) ? COL_TOP : col_n + inc;
      endfunction

      function void grow();
         if (cur_len < LEN_TOP) cur_len++;
      endfunction

      function void new_buffer();
         mode = MODE_IDLE; line_n = 1; col_n = 1;
      endfunction

      function void fail(logic [1:0] code, logic [7:0] b);
         emit(KIND_ERROR, 0, cur_len, 0, code);
         if (b == 0) new_buffer();
         else mode = MODE_DROP;
      endfunction

      function logic [8:0] keyword_slot();
         logic [KW_BITS-1:0] key;
         key = '0;
         if (cur_len == 0 || cur_len > KW_MAX_CHARS) return 0;
         for (int i = 0; i < cur_len; i++) key = {key[KW_BITS-9:0], wbuf[i]};
         for (int s = 0; s < KW_COUNT && s < 512; s++)
            if (KW_TABLE[s] == key) return 9'(s + 1);
         return 0;
      endfunction

      function void start_token(logic [7:0] b);
         logic [4:0] kind;
         kind = KIND_EOF;
         mode = MODE_IDLE;
         if (is_space(b)) begin
            advance(b);
            return;
         end
         tok_line = line_n; tok_col = col_n; cur_len = 0;
         if (b == 0) begin
            emit(KIND_EOF, 0, 0, 0, ERR_NONE);
            new_buffer();
            return;
         end
         case (b)
            ";": kind = KIND_SEMI;     "/": kind = KIND_SLASH;
            "{": kind = KIND_LBRACE;   "}": kind = KIND_RBRACE;
            ",": kind = KIND_COMMA;    "(": kind = KIND_LPAREN;
            ")": kind = KIND_RPAREN;   "[": kind = KIND_LBRACKET;
            "]": kind = KIND_RBRACKET; "*": kind = KIND_STAR;
            "%": kind = KIND_PERCENT;  "#": kind = KIND_HASH;
            "+": kind = KIND_PLUS;     "-": kind = KIND_MINUS;
            "=": kind = KIND_EQUAL;
            default: kind = KIND_EOF;
         endcase
         advance(b);
         cur_len = 1;
         if (kind != KIND_EOF) begin
            emit(kind, 0, 1, 0, ERR_NONE);
         end else if (b == ":" || b == "<" || b == ">" || b == "|" || b == "!") begin
            op_byte = b; mode = MODE_OP;
         end else if (b == "\"" || b == "'") begin
            quote = b; esc = 0; mode = MODE_STRING;
         end else if (is_digit(b)) begin
            num_val = 32'(b - "0"); ovf = 0; is_real = 0; mode = MODE_NUMBER;
         end else if (b == ".") begin
            mode = MODE_DOT;
         end else if (is_word_start(b)) begin
            wbuf[0] = upper(b); mode = MODE_WORD;
         end else begin
            emit(KIND_UNKNOWN, 0, 1, 0, ERR_NONE);
         end
      endfunction

      function void operator_next(logic [7:0] b);
         logic [4:0] pair, single;
         pair = KIND_EOF; single = KIND_EOF;
         if (op_byte == ":") begin
            if (b == "=") pair = KIND_ASSIGN; else single = KIND_COLON;
         end else if (op_byte == "<") begin
            if (b == "=") pair = KIND_LE;
            else if (b == ">") pair = KIND_NE;
            else single = KIND_LT;
         end else if (op_byte == ">") begin
            if (b == "=") pair = KIND_GE; else single = KIND_GT;
         end else if (op_byte == "|" && b == "|") pair = KIND_MERGE;
         else if (op_byte == "!" && b == "=") pair = KIND_NE;
         mode = MODE_IDLE;
         if (pair != KIND_EOF) begin
            advance(b);
            emit(pair, 0, 2, 0, ERR_NONE);
         end else if (single != KIND_EOF) begin
            emit(single, 0, 1, 0, ERR_NONE);
            start_token(b);
         end else if (b == 0 || is_space(b)) begin
            emit(KIND_UNKNOWN, 0, 1, 0, ERR_NONE);
            start_token(b);
         end else begin
            advance(b);
            emit(KIND_UNKNOWN, 0, 2, 0, ERR_NONE);
         end
      endfunction

      function void note_byte(logic [7:0] b);
         longint unsigned v;
         logic [8:0] kw;
         step_tokens.delete();
         case (mode)
            MODE_DROP: if (b == 0) new_buffer();
            MODE_OP: operator_next(b);
            MODE_DOT: begin
               if (is_digit(b)) begin
                  advance(b); grow();
                  is_real = 1; ovf = 0; num_val = 0; mode = MODE_NUMBER;
               end else begin
                  emit(KIND_DOT, 0, 1, 0, ERR_NONE);
                  start_token(b);
               end
            end
            MODE_NUMBER: begin
               if (is_digit(b) || b == ".") begin
                  if (b == ".") is_real = 1;
                  else if (!ovf) begin
                     v = longint'(num_val) * 10 + (b - "0");
                     if (v > INT_LIMIT) ovf = 1;
                     else num_val = v[31:0];
                  end
                  advance(b); grow();
               end else if (!is_real && ovf) begin
                  fail(ERR_OVERFLOW, b);
               end else begin
                  if (is_real) emit(KIND_REAL, 0, cur_len, 0, ERR_NONE);
                  else emit(KIND_INT, 0, cur_len, num_val, ERR_NONE);
                  start_token(b);
               end
            end
            MODE_WORD: begin
               if (is_word_start(b) || is_digit(b)) begin
                  if (cur_len < 64) wbuf[cur_len] = upper(b);
                  advance(b); grow();
               end else if (cur_len > 64) begin
                  fail(ERR_NAME, b);
               end else begin
                  kw = keyword_slot();
                  emit(kw != 0 ? KIND_KEYWORD : KIND_IDENT, kw, cur_len, 0, ERR_NONE);
                  start_token(b);
               end
            end
            MODE_STRING: begin
               if (esc) begin
                  if (b == 0) fail(ERR_STRING, b);
                  else begin
                     esc = 0; advance(b); grow();
                  end
               end else if (b == 0 || b == 8'd10 || b == 8'd13) begin
                  fail(ERR_STRING, b);
               end else begin
                  advance(b); grow();
                  if (b == quote) begin
                     emit(KIND_STRING, 0, cur_len, 0, ERR_NONE);
                     mode = MODE_IDLE;
                  end else if (b == "\\") esc = 1;
               end
            end
            default: start_token(b);
         endcase
         if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
         foreach (step_tokens[i]) expected.push_back(step_tokens[i]);
      endfunction

      task report(string what, longint got, longint want);
         mismatches++;
         if (mismatches <= 60)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      endtask

      task check(token_type got);
         token_type e;
         checked++;
         if (expected.size() == 0) begin
            report("unexpected token, kind", got.kind, -1);
            return;
         end
         e = expected.pop_front();
         if (got.kind !== e.kind) report("token_kind", got.kind, e.kind);
         if (got.kw !== e.kw) report("keyword_index", got.kw, e.kw);
         if (got.len !== e.len) report("token_length", got.len, e.len);
         if (got.line !== e.line) report("start_line", got.line, e.line);
         if (got.col !== e.col) report("start_column", got.col, e.col);
         if (got.val !== e.val) report("int_value", got.val, e.val);
         if (got.err !== e.err) report("error_code", got.err, e.err);
         if (got.last !== e.last) report("last", got.last, e.last);
      endtask
   endclass

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE = 400;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [4:0]  rsp_token_kind;
   logic [8:0]  rsp_keyword_index;
   logic [11:0] rsp_token_length;
   logic [19:0] rsp_start_line;
   logic [15:0] rsp_start_column;
   logic [30:0] rsp_int_value;
   logic [1:0]  rsp_error_code;
   logic        rsp_last;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   token_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int bytes_in = 0;
   logic [7:0] text[$];

   sql_token_scanner_unit uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      token_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_byte(req_in_byte);
            bytes_in++;
         end
         if (rsp_valid && rsp_ready) begin
            got.kind = rsp_token_kind; got.kw = rsp_keyword_index;
            got.len = rsp_token_length; got.line = rsp_start_line;
            got.col = rsp_start_column; got.val = rsp_int_value;
            got.err = rsp_error_code; got.last = rsp_last;
            sb.check(got);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   task send_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task send_text();
      foreach (text[i]) send_byte(text[i]);
      text.delete();
   endtask

   task send_str(input string s, input bit end_buffer);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      if (end_buffer) text.push_back(8'd0);
      send_text();
   endtask

   task settle();
      req_valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_tab(input logic [4:0] w);
      settle();
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= {27'd0, w};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.tab = w;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function logic [7:0] word_byte(bit first);
      int r;
      r = $urandom_range(first ? 52 : 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   function void gen_fragment();
      int r, n;
      logic [KW_BITS-1:0] kwv;
      logic [7:0] c;
      r = $urandom_range(99);
      if (r < 25) begin
         n = $urandom_range(99);
         if (n < 20) begin
            kwv = KW_TABLE[$urandom_range(KW_COUNT - 1)];
            for (int i = KW_MAX_CHARS - 1; i >= 0; i--) begin
               c = kwv[i*8 +: 8];
               if (c != 0) text.push_back((c >= "A" && c <= "Z" && $urandom_range(1))
                                          ? c + 8'd32 : c);
            end
         end else begin
            n = (n < 24) ? $urandom_range(60, 70) : (n < 28) ? $urandom_range(17, 34)
                                                              : $urandom_range(1, 8);
            text.push_back(word_byte(1));
            for (int i = 1; i < n; i++) text.push_back(word_byte(0));
         end
      end else if (r < 40) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            text.push_back(($urandom_range(11) == 0) ? "." : 8'("0" + $urandom_range(9)));
      end else if (r < 50) begin
         c = $urandom_range(1) ? "'" : "\"";
         text.push_back(c);
         n = $urandom_range(8);
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 10) begin
               text.push_back("\\");
               text.push_back(8'($urandom_range(1, 255)));
            end else if (r < 13) text.push_back($urandom_range(1) ? 8'd10 : 8'd13);
            else text.push_back(8'($urandom_range(32, 126)));
         end
         text.push_back(c);
      end else if (r < 65) begin
         case ($urandom_range(13))
            0: text.push_back(";");
            1: text.push_back($urandom_range(1) ? "(" : ")");
            2: text.push_back($urandom_range(1) ? "," : "*");
            3: begin text.push_back("|"); text.push_back("|"); end
            4: begin text.push_back("!"); text.push_back("="); end
            5: begin text.push_back("<"); text.push_back(">"); end
            6: begin text.push_back(":"); text.push_back("="); end
            7: text.push_back(":");
            8: begin text.push_back("<"); if ($urandom_range(1)) text.push_back("="); end
            9: begin text.push_back(">"); if ($urandom_range(1)) text.push_back("="); end
            10: text.push_back(".");
            11: text.push_back($urandom_range(1) ? "|" : "!");
            12: text.push_back("=");
            default: text.push_back("+");
         endcase
      end else if (r < 85) begin
         case ($urandom_range(5))
            0: text.push_back(8'd9);
            1: text.push_back(8'd10);
            2: text.push_back(8'($urandom_range(11, 13)));
            default: text.push_back(8'd32);
         endcase
      end else if (r < 92) begin
         text.push_back(8'd0);
      end else begin
         text.push_back(8'($urandom_range(255)));
      end
   endfunction

   task random_phase(input int count);
      int start;
      start = bytes_in;
      while (bytes_in - start < count) begin
         gen_fragment();
         send_text();
      end
      text.push_back(8'd0);
      send_text();
   endtask

   initial begin
      string s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_str("; / { } , ( ) [ ] * % # + - = || != <> := : <= < >= > .", 1);
      send_str("select Foo _x1 writeaccessmanager .5 1.2.3 7 2147483647", 1);
      send_str("2147483648 x", 1);
      send_str("'it\\'s' \"q\" 'a\\", 1);
      send_str("'abc", 1);
      send_str("'a\n b", 1);
      send_str("|x | !", 1);
      send_str("\t\x01 ~", 1);
      s = "";
      for (int i = 0; i < 70; i++) s = {s, "a"};
      send_str({s, " "}, 1);
      send_str(s, 1);
      send_str("99999999999", 1);

      write_tab(5'd16);
      send_str("\t\tx\ty\n\tz", 1);

      hold_request = 600;
      random_phase(350);

      write_tab(5'd1);
      send_idle_pct = 58;
      random_phase(350);

      write_tab(5'd8);
      send_idle_pct = 0;
      stall_pct = 58;
      random_phase(350);

      write_tab(5'($urandom_range(1, 16)));
      send_idle_pct = 10;
      stall_pct = 10;
      random_phase(350);

      settle();
      $display("summary: %0d text bytes in, %0d tokens compared, %0d mismatches",
               bytes_in, sb.checked, sb.mismatches);
      $display("summary: tab widths 16, 1, 8 and random; idle, stall and hold-off phases");
      if (sb.mismatches == 0 && sb.expected.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
